FILE: design/bgs_pkg.sv
// Shared sizes, codes and types of the bilinear grid sampler.
package bgs_pkg;

   // Grid geometry and sample width
   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int SAMPLE_BITS = 24;

   // Field widths of the ports
   localparam int OP_BITS      = 1;
   localparam int WCOL_BITS    = 8;
   localparam int WROW_BITS    = 8;
   localparam int VALUE_BITS   = 24;
   localparam int POS_BITS     = 32;
   localparam int SCALE_BITS   = 24;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   // Stored sample width: narrower samples keep their low bits only
   localparam int STORE_BITS = (SAMPLE_BITS < VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;

   // Index widths per axis
   localparam int COL_BITS  = $clog2(GRID_WIDTH);
   localparam int ROW_BITS  = $clog2(GRID_HEIGHT);
   localparam int AXIS_BITS = (COL_BITS > ROW_BITS) ? COL_BITS : ROW_BITS;

   // Four banks split by row and column parity
   localparam int BANKS      = 4;
   localparam int BANK_BITS  = 2;
   localparam int COL_HALF   = (GRID_WIDTH + 1) / 2;
   localparam int ROW_HALF   = (GRID_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = COL_HALF * ROW_HALF;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   // Axis mapping arithmetic
   localparam int DIFF_BITS = POS_BITS + 1;
   localparam int GRID_BITS = DIFF_BITS + SCALE_BITS + 1;
   localparam int CELL_BITS = GRID_BITS - 32;

   // Weights and accumulation
   localparam int WT_BITS    = 17;
   localparam int WPROD_BITS = 33;
   localparam int ONE_Q16    = 65536;
   localparam int PROD_BITS  = STORE_BITS + WPROD_BITS + 1;
   localparam int ACC_BITS   = 60;
   localparam int OUT_LSB    = 32;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_ORIGIN_X = 2'd0,
      CSR_ORIGIN_Y = 2'd1,
      CSR_SCALE_X  = 2'd2,
      CSR_SCALE_Y  = 2'd3
   } csr_index_type;

   // Clamped cell, clamped neighbor and Q1.16 weight of one axis
   typedef struct packed {
      logic [AXIS_BITS-1:0] base;
      logic [AXIS_BITS-1:0] next;
      logic [WT_BITS-1:0]   wt;
   } axis_loc_type;

   // Parities that route bank read data to the four corners
   typedef struct packed {
      logic col_cell;
      logic col_next;
      logic row_cell;
      logic row_next;
   } bank_sel_type;

endpackage

FILE: design/bgs_axis_map.sv
// Three-stage mapping of one axis position to a clamped cell, neighbor and weight.
module bgs_axis_map (
   input  logic                                     clock,
   input  logic [2:0]                               stage_en,
   input  logic signed [bgs_pkg::POS_BITS-1:0]      pos,
   input  logic signed [bgs_pkg::POS_BITS-1:0]      origin,
   input  logic [bgs_pkg::SCALE_BITS-1:0]           scale,
   input  logic [bgs_pkg::AXIS_BITS-1:0]            last_idx,
   output bgs_pkg::axis_loc_type                    loc
);
   import bgs_pkg::*;

   localparam logic signed [GRID_BITS-1:0] HALF_Q32 = GRID_BITS'(64'sd2147483648);

   logic signed [DIFF_BITS-1:0] diff_ff, diff_in;
   logic signed [GRID_BITS-1:0] prod_ff, prod_in;
   axis_loc_type                loc_ff, loc_in;

   logic signed [GRID_BITS-1:0] grid_pos;
   logic signed [CELL_BITS-1:0] cell_raw;
   logic signed [CELL_BITS-1:0] last_ext;

   // Offset from the grid edge
   assign diff_in = $signed({pos[POS_BITS-1], pos}) - $signed({origin[POS_BITS-1], origin});

   // Scale into grid units, Q.32
   assign prod_in = diff_ff * $signed({1'b0, scale});

   // Shift by one half, floor, clamp both ends
   always_comb begin
      grid_pos = prod_ff - HALF_Q32;
      cell_raw = grid_pos[GRID_BITS-1:32];
      last_ext = $signed({{(CELL_BITS-AXIS_BITS){1'b0}}, last_idx});
      if (cell_raw < 0) begin
         loc_in.base = '0;
         loc_in.wt   = '0;
      end else if (cell_raw > last_ext) begin
         loc_in.base = last_idx;
         loc_in.wt   = WT_BITS'(ONE_Q16);
      end else begin
         loc_in.base = cell_raw[AXIS_BITS-1:0];
         loc_in.wt   = {1'b0, grid_pos[31:16]};
      end
      loc_in.next = (loc_in.base == last_idx) ? last_idx : loc_in.base + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         diff_ff <= diff_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[2]) begin
         loc_ff <= loc_in;
      end
   end

   assign loc = loc_ff;

endmodule

FILE: design/bgs_grid_banks.sv
// Grid storage in four parity banks: one write and four parallel reads per cycle, reads only with load_en.
module bgs_grid_banks (
   input  logic                                    clock,
   input  logic                                    load_en,
   input  bgs_pkg::axis_loc_type                   col_loc,
   input  bgs_pkg::axis_loc_type                   row_loc,
   input  logic                                    wr_en,
   input  logic [bgs_pkg::COL_BITS-1:0]            wr_col,
   input  logic [bgs_pkg::ROW_BITS-1:0]            wr_row,
   input  logic [bgs_pkg::STORE_BITS-1:0]          wr_value,
   output logic [bgs_pkg::STORE_BITS-1:0]          rd_data [bgs_pkg::BANKS],
   output bgs_pkg::bank_sel_type                   sel
);
   import bgs_pkg::*;

   logic [COL_BITS-1:0]  col_cell, col_next, col_src [2];
   logic [ROW_BITS-1:0]  row_cell, row_next, row_src [2];
   logic [BANK_AW-1:0]   rd_addr [BANKS];
   logic [BANK_AW-1:0]   wr_addr;
   logic [BANK_BITS-1:0] wr_bank;
   bank_sel_type         sel_ff, sel_in;

   assign col_cell = COL_BITS'(col_loc.base);
   assign col_next = COL_BITS'(col_loc.next);
   assign row_cell = ROW_BITS'(row_loc.base);
   assign row_next = ROW_BITS'(row_loc.next);

   // Pick, per parity, whichever of cell and neighbor lives in that bank
   always_comb begin
      for (int p = 0; p < 2; p++) begin
         col_src[p] = (col_cell[0] == 1'(p)) ? col_cell : col_next;
         row_src[p] = (row_cell[0] == 1'(p)) ? row_cell : row_next;
      end
      for (int b = 0; b < BANKS; b++) begin
         rd_addr[b] = BANK_AW'(32'(row_src[b / 2] >> 1) * COL_HALF
                               + 32'(col_src[b % 2] >> 1));
      end
   end

   assign wr_bank = {wr_row[0], wr_col[0]};
   assign wr_addr = BANK_AW'(32'(wr_row >> 1) * COL_HALF + 32'(wr_col >> 1));

   assign sel_in.col_cell = col_cell[0];
   assign sel_in.col_next = col_next[0];
   assign sel_in.row_cell = row_cell[0];
   assign sel_in.row_next = row_next[0];

   for (genvar b = 0; b < BANKS; b++) begin : g_bank
      logic [STORE_BITS-1:0] mem [BANK_DEPTH];
      logic [STORE_BITS-1:0] rd_ff;

      // Write on a write transfer; read into the output register while load is enabled
      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == BANK_BITS'(b)) begin
            mem[wr_addr] <= wr_value;
         end
         if (load_en) begin
            rd_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         sel_ff <= sel_in;
      end
   end

   assign sel = sel_ff;

endmodule

FILE: design/bgs_blend.sv
// Corner weights, weighted corner products and the final floored sum.
module bgs_blend (
   input  logic                                    clock,
   input  logic [2:0]                              stage_en,
   input  logic [bgs_pkg::WT_BITS-1:0]             wx,
   input  logic [bgs_pkg::WT_BITS-1:0]             wy,
   input  logic [bgs_pkg::STORE_BITS-1:0]          rd_data [bgs_pkg::BANKS],
   input  bgs_pkg::bank_sel_type                   sel,
   output logic signed [bgs_pkg::VALUE_BITS-1:0]   sampled_value
);
   import bgs_pkg::*;

   logic [WT_BITS-1:0]           bx, by;
   logic [WPROD_BITS-1:0]        wt_ff [BANKS];
   logic [WPROD_BITS-1:0]        wt_in [BANKS];
   logic signed [ACC_BITS-1:0]   prod_ff [BANKS];
   logic signed [ACC_BITS-1:0]   prod_in [BANKS];
   logic signed [PROD_BITS-1:0]  prod [BANKS];
   logic [STORE_BITS-1:0]        corner [BANKS];
   logic [BANK_BITS-1:0]         bank_of [BANKS];
   logic signed [ACC_BITS-1:0]   sum;
   logic signed [VALUE_BITS-1:0] result_ff;

   // Corner order: cell/cell, cell row next column, next row cell column, next/next
   always_comb begin
      bx = WT_BITS'(ONE_Q16) - wx;
      by = WT_BITS'(ONE_Q16) - wy;
      wt_in[0] = WPROD_BITS'(bx * by);
      wt_in[1] = WPROD_BITS'(wx * by);
      wt_in[2] = WPROD_BITS'(bx * wy);
      wt_in[3] = WPROD_BITS'(wx * wy);
   end

   // Route banks to corners and weight each corner
   always_comb begin
      for (int c = 0; c < BANKS; c++) begin
         bank_of[c][1] = (c / 2 == 1) ? sel.row_next : sel.row_cell;
         bank_of[c][0] = (c % 2 == 1) ? sel.col_next : sel.col_cell;
         corner[c]     = rd_data[bank_of[c]];
         prod[c]       = $signed(corner[c]) * $signed({1'b0, wt_ff[c]});
         prod_in[c]    = {{(ACC_BITS-PROD_BITS){prod[c][PROD_BITS-1]}}, prod[c]};
      end
   end

   // Add the four terms; the arithmetic shift floors
   assign sum = (prod_ff[0] + prod_ff[1]) + (prod_ff[2] + prod_ff[3]);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         wt_ff <= wt_in;
      end
      if (stage_en[1]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[2]) begin
         result_ff <= sum[OUT_LSB+VALUE_BITS-1:OUT_LSB];
      end
   end

   assign sampled_value = result_ff;

endmodule

FILE: design/bilinear_grid_sampler.sv
// Top level of the bilinear grid sampler: handshakes, registers and the stage chain.
//
// The sampler holds a GRID_WIDTH x GRID_HEIGHT grid of signed samples and answers
// position queries with a bilinear blend of the four surrounding samples, edges
// clamped. A write item (operation 0) stores one sample and gives no result; a
// query item (operation 1) gives one result. Items enter at one per cycle while
// req_ready is high; a query passes the stages offset, scale multiply, clamp, bank
// read with weight products, corner multiply and sum, and its result leaves when
// the result side takes it. The grid sits in four banks split by row and column
// parity, so the four corners of a query are read in the same cycle; writes take
// the bank port in the same stage, so a query sees every earlier write. Each stage
// holds while its successor is full and cannot move on, so bubbles close up during
// a result stall. Grid entries are undefined until written and there is no clearing
// pass after reset. The register port is always ready and takes a write every cycle;
// the user must change registers only while no item is in flight; this is not enforced.
module bilinear_grid_sampler (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [bgs_pkg::OP_BITS-1:0]              req_operation,
   input  logic [bgs_pkg::WCOL_BITS-1:0]            req_write_col,
   input  logic [bgs_pkg::WROW_BITS-1:0]            req_write_row,
   input  logic signed [bgs_pkg::VALUE_BITS-1:0]    req_write_value,
   input  logic signed [bgs_pkg::POS_BITS-1:0]      req_query_x,
   input  logic signed [bgs_pkg::POS_BITS-1:0]      req_query_y,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [bgs_pkg::VALUE_BITS-1:0]    rsp_sampled_value,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [bgs_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [bgs_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);
   import bgs_pkg::*;

   localparam int STAGES = 6;

   // Configuration registers
   logic signed [POS_BITS-1:0] origin_x_ff, origin_y_ff;
   logic [SCALE_BITS-1:0]      scale_x_ff, scale_y_ff;

   // Stage valid bits and load enables
   logic [STAGES-1:0] valid_ff, valid_in, stage_rdy;

   // Write payload carried through the first three stages
   logic [OP_BITS-1:0]    op_ff [3];
   logic [WCOL_BITS-1:0]  wcol_ff [3];
   logic [WROW_BITS-1:0]  wrow_ff [3];
   logic [STORE_BITS-1:0] wval_ff [3];

   logic                  in_range;
   logic                  wr_en;
   axis_loc_type          col_loc, row_loc;
   logic [STORE_BITS-1:0] rd_data [BANKS];
   bank_sel_type          sel;

   assign csr_ready = 1'b1;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         scale_x_ff  <= SCALE_BITS'(ONE_Q16);
         scale_y_ff  <= SCALE_BITS'(ONE_Q16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ORIGIN_X: origin_x_ff <= $signed(csr_wdata[POS_BITS-1:0]);
            CSR_ORIGIN_Y: origin_y_ff <= $signed(csr_wdata[POS_BITS-1:0]);
            CSR_SCALE_X:  scale_x_ff  <= csr_wdata[SCALE_BITS-1:0];
            CSR_SCALE_Y:  scale_y_ff  <= csr_wdata[SCALE_BITS-1:0];
            default:      ;
         endcase
      end
   end

   // Each stage loads when empty or when its successor moves on
   always_comb begin
      stage_rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
      // Drop write items once they reach the banks
      valid_in[3] = valid_ff[2] && (op_type'(op_ff[2]) == OP_SAMPLE);
   end

   assign req_ready = stage_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_rdy[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Carry the write fields alongside the axis mapping
   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         op_ff[0]   <= req_operation;
         wcol_ff[0] <= req_write_col;
         wrow_ff[0] <= req_write_row;
         wval_ff[0] <= req_write_value[STORE_BITS-1:0];
      end
      for (int k = 1; k < 3; k++) begin
         if (stage_rdy[k]) begin
            op_ff[k]   <= op_ff[k-1];
            wcol_ff[k] <= wcol_ff[k-1];
            wrow_ff[k] <= wrow_ff[k-1];
            wval_ff[k] <= wval_ff[k-1];
         end
      end
   end

   // Ignore writes outside the grid
   assign in_range = (32'(wcol_ff[2]) < 32'(GRID_WIDTH)) && (32'(wrow_ff[2]) < 32'(GRID_HEIGHT));
   assign wr_en    = valid_ff[2] && stage_rdy[3] && (op_type'(op_ff[2]) == OP_WRITE) && in_range;

   bgs_axis_map u_map_x (
      .clock    (clock),
      .stage_en (stage_rdy[2:0]),
      .pos      (req_query_x),
      .origin   (origin_x_ff),
      .scale    (scale_x_ff),
      .last_idx (AXIS_BITS'(GRID_WIDTH - 1)),
      .loc      (col_loc)
   );

   bgs_axis_map u_map_y (
      .clock    (clock),
      .stage_en (stage_rdy[2:0]),
      .pos      (req_query_y),
      .origin   (origin_y_ff),
      .scale    (scale_y_ff),
      .last_idx (AXIS_BITS'(GRID_HEIGHT - 1)),
      .loc      (row_loc)
   );

   bgs_grid_banks u_banks (
      .clock    (clock),
      .load_en  (stage_rdy[3]),
      .col_loc  (col_loc),
      .row_loc  (row_loc),
      .wr_en    (wr_en),
      .wr_col   (COL_BITS'(wcol_ff[2])),
      .wr_row   (ROW_BITS'(wrow_ff[2])),
      .wr_value (wval_ff[2]),
      .rd_data  (rd_data),
      .sel      (sel)
   );

   bgs_blend u_blend (
      .clock         (clock),
      .stage_en      (stage_rdy[5:3]),
      .wx            (col_loc.wt),
      .wy            (row_loc.wt),
      .rd_data       (rd_data),
      .sel           (sel),
      .sampled_value (rsp_sampled_value)
   );

   assign rsp_valid = valid_ff[STAGES-1];

endmodule

FILE: dv/tb_bilinear_grid_sampler.sv
// Self-checking testbench for the bilinear grid sampler: directed edge tests and random traffic.
module tb_bilinear_grid_sampler;
   import bgs_pkg::*;

   localparam int Q16_ONE       = 65536;
   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 850;
   localparam int PHASE_ITEMS   = 120;
   localparam int CYCLE_LIMIT   = 1000000;

   localparam logic signed [POS_BITS-1:0]   POS_MIN   = 32'sh8000_0000;
   localparam logic signed [POS_BITS-1:0]   POS_MAX   = 32'sh7fff_ffff;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 24'sh80_0000;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 24'sh7f_ffff;
   localparam logic [SCALE_BITS-1:0]        SCALE_MAX = 24'hff_ffff;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   // One input item as it crosses the request channel
   typedef struct {
      op_type                       op;
      logic [WCOL_BITS-1:0]         col;
      logic [WROW_BITS-1:0]         row;
      logic signed [VALUE_BITS-1:0] value;
      logic signed [POS_BITS-1:0]   qx;
      logic signed [POS_BITS-1:0]   qy;
   } sampler_req_type;

   // Clamped grid index, clamped neighbor and Q1.16 weight along one axis
   typedef struct {
      int     idx;
      int     nbr;
      longint wt;
   } axis_pick_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [OP_BITS-1:0]           req_operation;
   logic [WCOL_BITS-1:0]         req_write_col;
   logic [WROW_BITS-1:0]         req_write_row;
   logic signed [VALUE_BITS-1:0] req_write_value;
   logic signed [POS_BITS-1:0]   req_query_x;
   logic signed [POS_BITS-1:0]   req_query_y;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [VALUE_BITS-1:0] rsp_sampled_value;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_IDX_BITS-1:0]      csr_index;
   logic [CSR_DATA_BITS-1:0]     csr_wdata;

   // Shadow copy of the block state
   logic signed [POS_BITS-1:0]   origin_x_cfg;
   logic signed [POS_BITS-1:0]   origin_y_cfg;
   logic [SCALE_BITS-1:0]        scale_x_cfg;
   logic [SCALE_BITS-1:0]        scale_y_cfg;
   logic signed [VALUE_BITS-1:0] sample_grid [GRID_WIDTH*GRID_HEIGHT];
   bit                           grid_loaded [GRID_WIDTH*GRID_HEIGHT];

   logic signed [VALUE_BITS-1:0] blend_due_q [$];
   logic signed [VALUE_BITS-1:0] blend_due;
   int                           blend_mismatches = 0;
   int                           items_sent = 0;
   int                           burst_left = 0;
   bit                           sender_gaps = 1'b1;
   int                           cycle_count = 0;
   int                           walk_gx;
   int                           walk_gy;

   bilinear_grid_sampler DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_write_col     (req_write_col),
      .req_write_row     (req_write_row),
      .req_write_value   (req_write_value),
      .req_query_x       (req_query_x),
      .req_query_y       (req_query_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sampled_value (rsp_sampled_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // Map a position to its grid index, neighbor and weight; clamp at both ends
   function automatic axis_pick_type locate_axis(input logic signed [POS_BITS-1:0] pos,
                                                 input logic signed [POS_BITS-1:0] org,
                                                 input logic [SCALE_BITS-1:0] scl,
                                                 input int size);
      axis_pick_type p;
      longint        grid_q32;
      longint        whole;
      grid_q32 = (longint'(pos) - longint'(org)) * longint'(scl) - (longint'(1) <<< 31);
      whole    = grid_q32 >>> 32;
      p.wt     = longint'(grid_q32[31:16]);
      if (whole < 0) begin
         whole = 0;
         p.wt  = 0;
      end else if (whole > size - 1) begin
         whole = size - 1;
         p.wt  = Q16_ONE;
      end
      p.idx = int'(whole);
      p.nbr = (p.idx + 1 > size - 1) ? size - 1 : p.idx + 1;
      return p;
   endfunction

   // Blend the four corners with the current registers; floor after the 32-bit shift
   function automatic logic signed [VALUE_BITS-1:0] blend_at(
      input logic signed [POS_BITS-1:0] qx,
      input logic signed [POS_BITS-1:0] qy);
      axis_pick_type ax;
      axis_pick_type ay;
      longint        bx;
      longint        by;
      longint        acc;
      ax  = locate_axis(qx, origin_x_cfg, scale_x_cfg, GRID_WIDTH);
      ay  = locate_axis(qy, origin_y_cfg, scale_y_cfg, GRID_HEIGHT);
      bx  = Q16_ONE - ax.wt;
      by  = Q16_ONE - ay.wt;
      acc = longint'(sample_grid[ay.idx*GRID_WIDTH + ax.idx]) * (bx * by)
          + longint'(sample_grid[ay.nbr*GRID_WIDTH + ax.idx]) * (bx * ay.wt)
          + longint'(sample_grid[ay.idx*GRID_WIDTH + ax.nbr]) * (ax.wt * by)
          + longint'(sample_grid[ay.nbr*GRID_WIDTH + ax.nbr]) * (ax.wt * ay.wt);
      acc = acc >>> 32;
      return acc[VALUE_BITS-1:0];
   endfunction

   // Find a position that lands on a given grid coordinate (Q16 grid units)
   function automatic logic signed [POS_BITS-1:0] grid_to_pos(
      input int grid_q16,
      input logic signed [POS_BITS-1:0] org,
      input logic [SCALE_BITS-1:0] scl);
      longint span;
      if (scl == 0)
         return POS_BITS'($urandom());
      span = (longint'(grid_q16) * Q16_ONE + (longint'(1) <<< 31)) / longint'(scl);
      return POS_BITS'(longint'(org) + span);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_sample_value();
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return '0;
         3:       return '1;
         default: return VALUE_BITS'($urandom());
      endcase
   endfunction

   // Send one item in bursts, with random gaps when sender_gaps is set; update the shadow state on its transfer
   task automatic send_item(input sampler_req_type it);
      logic signed [VALUE_BITS-1:0] kept;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (sender_gaps) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_operation   <= it.op;
      req_write_col   <= it.col;
      req_write_row   <= it.row;
      req_write_value <= it.value;
      req_query_x     <= it.qx;
      req_query_y     <= it.qy;
      do @(negedge clock); while (!req_ready);
      if (it.op == OP_WRITE) begin
         // narrow samples keep their low bits only
         kept = (it.value <<< (VALUE_BITS - STORE_BITS)) >>> (VALUE_BITS - STORE_BITS);
         if (it.col < GRID_WIDTH && it.row < GRID_HEIGHT) begin
            sample_grid[it.row*GRID_WIDTH + it.col] = kept;
            grid_loaded[it.row*GRID_WIDTH + it.col] = 1'b1;
         end
      end else begin
         blend_due_q.push_back(blend_at(it.qx, it.qy));
      end
      items_sent++;
      @(posedge clock);
   endtask

   task automatic write_sample(input logic [WCOL_BITS-1:0] col,
                               input logic [WROW_BITS-1:0] row,
                               input logic signed [VALUE_BITS-1:0] value);
      sampler_req_type it;
      it.op    = OP_WRITE;
      it.col   = col;
      it.row   = row;
      it.value = value;
      it.qx    = POS_BITS'($urandom());
      it.qy    = POS_BITS'($urandom());
      send_item(it);
   endtask

   // Query a position; load first any corner it reads that was never written
   task automatic query_at(input logic signed [POS_BITS-1:0] qx,
                           input logic signed [POS_BITS-1:0] qy);
      axis_pick_type   ax;
      axis_pick_type   ay;
      int              col;
      int              row;
      sampler_req_type it;
      ax = locate_axis(qx, origin_x_cfg, scale_x_cfg, GRID_WIDTH);
      ay = locate_axis(qy, origin_y_cfg, scale_y_cfg, GRID_HEIGHT);
      for (int k = 0; k < 4; k++) begin
         col = k[0] ? ax.nbr : ax.idx;
         row = k[1] ? ay.nbr : ay.idx;
         if (!grid_loaded[row*GRID_WIDTH + col])
            write_sample(WCOL_BITS'(col), WROW_BITS'(row), pick_sample_value());
      end
      it.op    = OP_SAMPLE;
      it.col   = WCOL_BITS'($urandom());
      it.row   = WROW_BITS'($urandom());
      it.value = VALUE_BITS'($urandom());
      it.qx    = qx;
      it.qy    = qy;
      send_item(it);
   endtask

   // Drop valid, wait for every result, then let trailing writes retire
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (blend_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      case (idx)
         CSR_ORIGIN_X: origin_x_cfg = data;
         CSR_ORIGIN_Y: origin_y_cfg = data;
         CSR_SCALE_X:  scale_x_cfg  = data[SCALE_BITS-1:0];
         CSR_SCALE_Y:  scale_y_cfg  = data[SCALE_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_BITS-1:0] ox,
                             input logic [CSR_DATA_BITS-1:0] oy,
                             input logic [CSR_DATA_BITS-1:0] sx,
                             input logic [CSR_DATA_BITS-1:0] sy);
      drain_pipeline();
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_SCALE_X, sx);
      csr_write(CSR_SCALE_Y, sy);
   endtask

   // Exact sample points, half and quarter blends with the default mapping
   task automatic test_exact_points();
      write_sample(0, 0, VALUE_MAX);
      write_sample(1, 0, VALUE_MIN);
      write_sample(0, 1, '0);
      write_sample(1, 1, '1);
      query_at(0, 0);
      query_at(Q16_ONE, Q16_ONE);
      query_at(Q16_ONE + Q16_ONE/2, Q16_ONE/2);
      query_at(Q16_ONE + Q16_ONE/4, 3*Q16_ONE/4);
   endtask

   // Far below and above the grid, the last sample, and the last one blending with itself
   task automatic test_grid_clamps();
      write_sample(255, 255, VALUE_MIN);
      write_sample(255, 0, VALUE_MAX);
      query_at(POS_MIN, POS_MIN);
      query_at(POS_MAX, POS_MAX);
      query_at(POS_MAX, POS_MIN);
      query_at(255*Q16_ONE + Q16_ONE/2, 255*Q16_ONE + Q16_ONE/2);
      query_at(256*Q16_ONE, 3*Q16_ONE);
      query_at(256*Q16_ONE + Q16_ONE/2, 100*Q16_ONE);
   endtask

   // A zero scale folds every position onto the first cell
   task automatic test_zero_scale();
      set_config($urandom(), $urandom(), 0, 0);
      query_at(POS_BITS'($urandom()), POS_BITS'($urandom()));
      query_at(POS_MIN, POS_MAX);
   endtask

   // Origins and scales at their extremes
   task automatic test_extreme_registers();
      set_config(POS_MIN, POS_MAX, SCALE_MAX, SCALE_MAX);
      query_at(POS_MIN + Q16_ONE, POS_MAX);
      query_at(POS_MIN, POS_MIN);
      query_at(POS_MAX, POS_MAX);
      set_config(POS_MAX, POS_MIN, 1, 1);
      query_at(POS_MAX, POS_MIN);
      query_at(POS_MIN, POS_MAX);
   endtask

   // Random phases: new registers, then mostly texture-like walks over the grid
   task automatic test_random_traffic();
      int phase;
      int start;
      int pick;
      phase = 0;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         case (phase % 8)
            0: set_config(0, 0, Q16_ONE, Q16_ONE);
            1: set_config(POS_MIN, POS_MAX, Q16_ONE, Q16_ONE/2);
            2: set_config($urandom(), $urandom(), SCALE_MAX, SCALE_MAX);
            3: set_config($urandom(), $urandom(), 0, $urandom_range(1, SCALE_MAX));
            4: set_config(int'($urandom_range(0, 1 << 21)) - (1 << 20),
                          int'($urandom_range(0, 1 << 21)) - (1 << 20),
                          $urandom_range(Q16_ONE/4, 4*Q16_ONE),
                          $urandom_range(Q16_ONE/4, 4*Q16_ONE));
            5: set_config(POS_MAX, POS_MIN, SCALE_MAX, 1);
            6: set_config($urandom(), $urandom(), $urandom_range(1, 4096),
                          $urandom_range(Q16_ONE, SCALE_MAX));
            default: set_config($urandom(), $urandom(), $urandom(), $urandom());
         endcase
         sender_gaps = ($urandom_range(0, 3) != 0);
         walk_gx = int'($urandom_range(0, 256*Q16_ONE));
         walk_gy = int'($urandom_range(0, 256*Q16_ONE));
         repeat (PHASE_ITEMS) begin
            if (items_sent - start >= RANDOM_ITEMS)
               break;
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               write_sample(WCOL_BITS'($urandom()), WROW_BITS'($urandom()),
                            pick_sample_value());
            end else if (pick < 85) begin
               // step locally most of the time, jump now and then
               if (pick < 60) begin
                  walk_gx += int'($urandom_range(0, 4*Q16_ONE)) - 2*Q16_ONE;
                  walk_gy += int'($urandom_range(0, 4*Q16_ONE)) - 2*Q16_ONE;
               end else begin
                  walk_gx = int'($urandom_range(0, 260*Q16_ONE)) - 2*Q16_ONE;
                  walk_gy = int'($urandom_range(0, 260*Q16_ONE)) - 2*Q16_ONE;
               end
               if (walk_gx < -2*Q16_ONE)  walk_gx = -2*Q16_ONE;
               if (walk_gx > 258*Q16_ONE) walk_gx = 258*Q16_ONE;
               if (walk_gy < -2*Q16_ONE)  walk_gy = -2*Q16_ONE;
               if (walk_gy > 258*Q16_ONE) walk_gy = 258*Q16_ONE;
               query_at(grid_to_pos(walk_gx, origin_x_cfg, scale_x_cfg),
                        grid_to_pos(walk_gy, origin_y_cfg, scale_y_cfg));
            end else begin
               query_at(POS_BITS'($urandom()), POS_BITS'($urandom()));
            end
         end
         phase++;
      end
   endtask

   // Compare each result transfer with the oldest pending blend
   always @(negedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (blend_due_q.size() == 0) begin
            $error("sampled_value: result with none pending, expected none, actual %0d",
                   rsp_sampled_value);
            blend_mismatches++;
         end else begin
            blend_due = blend_due_q.pop_front();
            if (rsp_sampled_value !== blend_due) begin
               $error("sampled_value mismatch: expected %0d, actual %0d",
                      blend_due, rsp_sampled_value);
               blend_mismatches++;
            end
         end
      end
   end

   // Result-side backpressure: modes of random length
   initial begin : rsp_stall
      stall_mode_type mode;
      int             mode_left;
      int             period;
      int             duty;
      int             tick;
      int             hold;
      logic           level;
      rsp_ready = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      period    = 2;
      duty      = 1;
      tick      = 0;
      hold      = 0;
      level     = 1'b1;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(30, 300);
            period    = $urandom_range(2, 9);
            duty      = $urandom_range(1, period - 1);
         end
         mode_left--;
         tick++;
         case (mode)
            STALL_NONE:     rsp_ready <= 1'b1;
            STALL_RANDOM:   rsp_ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_ready <= (tick % period) < duty;
            default: begin
               if (hold == 0) begin
                  level = ~level;
                  hold  = level ? $urandom_range(1, 10) : $urandom_range(1, 24);
               end
               hold--;
               rsp_ready <= level;
            end
         endcase
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_WRITE;
      req_write_col   = '0;
      req_write_row   = '0;
      req_write_value = '0;
      req_query_x     = '0;
      req_query_y     = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_ORIGIN_X;
      csr_wdata       = '0;
      origin_x_cfg    = '0;
      origin_y_cfg    = '0;
      scale_x_cfg     = SCALE_BITS'(Q16_ONE);
      scale_y_cfg     = SCALE_BITS'(Q16_ONE);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_exact_points();
      test_grid_clamps();
      test_zero_scale();
      test_extreme_registers();
      test_random_traffic();
      drain_pipeline();

      if (blend_mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: files.f
design/bgs_pkg.sv
design/bgs_axis_map.sv
design/bgs_grid_banks.sv
design/bgs_blend.sv
design/bilinear_grid_sampler.sv
dv/tb_bilinear_grid_sampler.sv
